FILE: rtl/core/serial_arm_forward_kinematics_macros.svh
// Assertion macros for the serial arm forward kinematics block.
// Included by the RTL files that carry concurrent assertions.
`ifndef SERIAL_ARM_FORWARD_KINEMATICS_MACROS_SVH
`define SERIAL_ARM_FORWARD_KINEMATICS_MACROS_SVH
`ifndef SYNTH
`define SFK_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfk assertion failed");
`define SFK_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfk assertion failed");
`else
`define SFK_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SFK_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/core/sfk_pkg.sv
// Shared types, constants and tables of the serial arm forward kinematics block.
// No dependencies.
package sfk_pkg;

    localparam int NUM_JOINTS  = 7;
    localparam int FRAC_BITS   = 16;
    localparam int ROT_W       = FRAC_BITS + 2;
    localparam int POS_W       = FRAC_BITS + 5;
    localparam int CORDIC_STEPS = 20;
    localparam int TAB_ROWS    = 7;
    localparam int PROD_W      = 2 * ROT_W;
    localparam int ACC_W       = PROD_W + 2;
    localparam int RND_W       = ACC_W - FRAC_BITS;

    typedef logic signed [ROT_W-1:0] t_rot;
    typedef logic signed [POS_W-1:0] t_pos;

    typedef enum logic [1:0] {TW_NONE, TW_XY, TW_X} t_twist;

    typedef enum logic [1:0] {S_IDLE, S_TRIG, S_MAC, S_EMIT} t_state;

    typedef struct packed {
        logic start;
        logic clear;
    } t_pose_cmd;

    localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
        32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304
    };

    localparam logic [31:0] CORDIC_K = 32'd652032874;

    // link offsets, meters in Q.16
    localparam t_rot FRAME_T [TAB_ROWS][3] = '{
        '{18'sd0, 18'sd0, 18'sd13271}, '{18'sd0, 18'sd13402, 18'sd0},
        '{18'sd0, 18'sd0, 18'sd14123}, '{18'sd0, 18'sd12091, 18'sd0},
        '{18'sd0, 18'sd0, 18'sd14123}, '{18'sd0, 18'sd5308, 18'sd0},
        '{18'sd0, 18'sd0, 18'sd2949}
    };

    localparam t_rot MASS_T [TAB_ROWS][3] = '{
        '{18'sd0, -18'sd1966, 18'sd7864}, '{18'sd20, 18'sd3867, 18'sd2753},
        '{18'sd0, 18'sd1966, 18'sd8520}, '{18'sd0, 18'sd4391, 18'sd2228},
        '{18'sd7, 18'sd1376, 18'sd4981}, '{18'sd0, 18'sd39, 18'sd26},
        '{18'sd0, 18'sd0, 18'sd1311}
    };

    localparam t_twist TWIST_TAB [TAB_ROWS] = '{
        TW_XY, TW_XY, TW_X, TW_XY, TW_X, TW_XY, TW_NONE
    };

    localparam t_pos BASE_Z = 21'sd10322;
    localparam t_rot ONE_ROT = t_rot'(1 << FRAC_BITS);

    function automatic t_rot sat_rot(input logic signed [RND_W:0] v);
        logic signed [RND_W:0] hi;
        logic signed [RND_W:0] lo;
        hi = (RND_W+1)'((1 <<< (ROT_W - 1)) - 1);
        lo = -hi - 1;
        if (v > hi) return t_rot'(hi);
        if (v < lo) return t_rot'(lo);
        return t_rot'(v);
    endfunction

    function automatic t_pos sat_pos(input logic signed [RND_W:0] v);
        logic signed [RND_W:0] hi;
        logic signed [RND_W:0] lo;
        hi = (RND_W+1)'((1 <<< (POS_W - 1)) - 1);
        lo = -hi - 1;
        if (v > hi) return t_pos'(hi);
        if (v < lo) return t_pos'(lo);
        return t_pos'(v);
    endfunction

    function automatic t_rot neg_rot(input t_rot v);
        return sat_rot(-(RND_W+1)'(v));
    endfunction

endpackage

FILE: rtl/core/sfk_cordic.sv
// Iterative CORDIC producing cosine and sine of a binary angle in Q.16.
// Depends on sfk_pkg.
module sfk_cordic
    import sfk_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [15:0] i_angle,
    output logic               o_done,
    output t_rot               o_cos,
    output t_rot               o_sin
);

    logic signed [32:0] r_x, r_y;
    logic signed [33:0] r_z;
    logic [4:0]         r_i;
    logic               r_busy, r_neg, r_done;

    logic signed [16:0] a_ext, a_adj;
    logic               a_neg;
    logic signed [32:0] dx, dy;
    logic signed [33:0] atan_v;
    logic signed [32:0] x_rnd, y_rnd;
    logic signed [18:0] x_q, y_q;

    always_comb begin
        a_ext = 17'(i_angle);
        a_neg = 1'b0;
        a_adj = a_ext;
        if (a_ext > 17'sd16384) begin
            a_adj = a_ext - 17'sd32768;
            a_neg = 1'b1;
        end else if (a_ext < -17'sd16384) begin
            a_adj = a_ext + 17'sd32768;
            a_neg = 1'b1;
        end
        dx     = r_y >>> r_i;
        dy     = r_x >>> r_i;
        atan_v = 34'(ATAN_TAB[r_i[4:0]]);
        x_rnd  = r_x + 33'sd8192;
        y_rnd  = r_y + 33'sd8192;
        x_q    = r_neg ? -x_rnd[32:14] : x_rnd[32:14];
        y_q    = r_neg ? -y_rnd[32:14] : y_rnd[32:14];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                if (r_i == 5'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_i <= r_i + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= 33'(CORDIC_K);
            r_y   <= '0;
            r_z   <= 34'(a_adj) <<< 16;
            r_neg <= a_neg;
        end else if (r_busy) begin
            if (!r_z[33]) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - atan_v;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + atan_v;
            end
        end
    end

    assign o_done = r_done;
    assign o_cos  = x_q[ROT_W-1:0];
    assign o_sin  = y_q[ROT_W-1:0];

endmodule

FILE: rtl/core/sfk_pose.sv
// Running pose with one shared multiplier stepping through the joint update.
// Depends on sfk_pkg.
module sfk_pose
    import sfk_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_pose_cmd  i_cmd,
    input  t_rot       i_cos,
    input  t_rot       i_sin,
    input  logic [2:0] i_joint,
    input  logic       i_mass,
    output logic       o_done,
    output t_rot       o_rot [9],
    output t_pos       o_pos [3]
);

    t_rot r_rot [9];
    t_pos r_pos [3];
    logic [1:0] r_row;
    logic [2:0] r_step;
    logic       r_ph, r_busy, r_done;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    t_rot r_a0, r_a1;

    t_rot op_a, op_b, rr0, rr1, rr2;
    logic first, sub;
    logic signed [ACC_W-1:0] sum;
    logic signed [ACC_W-1:0] sum_r;
    logic signed [RND_W:0]   rnd_v;
    logic signed [RND_W:0]   pos_sum;
    t_twist tw;

    always_comb begin
        rr0   = r_rot[3*r_row];
        rr1   = r_rot[3*r_row + 1];
        rr2   = r_rot[3*r_row + 2];
        first = 1'b0;
        sub   = 1'b0;
        op_a  = rr0;
        op_b  = i_cos;
        case (r_step)
            3'd0: begin op_a = rr0; op_b = i_cos; first = 1'b1; end
            3'd1: begin op_a = rr1; op_b = i_sin; end
            3'd2: begin op_a = rr1; op_b = i_cos; first = 1'b1; end
            3'd3: begin op_a = rr0; op_b = i_sin; sub = 1'b1; end
            3'd4: begin
                op_a  = r_a0;
                op_b  = i_mass ? MASS_T[i_joint][0] : FRAME_T[i_joint][0];
                first = 1'b1;
            end
            3'd5: begin
                op_a = r_a1;
                op_b = i_mass ? MASS_T[i_joint][1] : FRAME_T[i_joint][1];
            end
            3'd6: begin
                op_a = rr2;
                op_b = i_mass ? MASS_T[i_joint][2] : FRAME_T[i_joint][2];
            end
            default: ;
        endcase
        sum     = (first ? '0 : r_acc)
                  + (sub ? -ACC_W'(r_prod) : ACC_W'(r_prod));
        sum_r   = sum + ACC_W'(1 << (FRAC_BITS - 1));
        rnd_v   = (RND_W+1)'(sum_r >>> FRAC_BITS);
        pos_sum = (RND_W+1)'(r_pos[r_row]) + rnd_v;
        tw      = TWIST_TAB[i_joint];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ph   <= 1'b0;
            r_row  <= '0;
            r_step <= '0;
            for (int k = 0; k < 9; k++) r_rot[k] <= (k % 4 == 0) ? ONE_ROT : '0;
            r_pos[0] <= '0;
            r_pos[1] <= '0;
            r_pos[2] <= BASE_Z;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.clear) begin
                for (int k = 0; k < 9; k++) r_rot[k] <= (k % 4 == 0) ? ONE_ROT : '0;
                r_pos[0] <= '0;
                r_pos[1] <= '0;
                r_pos[2] <= BASE_Z;
            end else if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_ph   <= 1'b0;
                r_row  <= '0;
                r_step <= '0;
            end else if (r_busy) begin
                r_ph <= ~r_ph;
                if (r_ph) begin
                    if (r_step == 3'd6) begin
                        r_pos[r_row] <= sat_pos(pos_sum);
                        case (tw)
                            TW_XY: begin
                                r_rot[3*r_row]     <= neg_rot(r_a0);
                                r_rot[3*r_row + 1] <= rr2;
                                r_rot[3*r_row + 2] <= r_a1;
                            end
                            TW_X: begin
                                r_rot[3*r_row]     <= r_a0;
                                r_rot[3*r_row + 1] <= rr2;
                                r_rot[3*r_row + 2] <= neg_rot(r_a1);
                            end
                            default: begin
                                r_rot[3*r_row]     <= r_a0;
                                r_rot[3*r_row + 1] <= r_a1;
                            end
                        endcase
                        r_step <= '0;
                        if (r_row == 2'd2) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                        end else begin
                            r_row <= r_row + 2'd1;
                        end
                    end else begin
                        r_step <= r_step + 3'd1;
                    end
                end
            end
        end
    end

    // product register, then accumulate on the second phase
    always_ff @(posedge i_clk) begin
        if (r_busy && !r_ph) r_prod <= op_a * op_b;
        if (r_busy && r_ph) begin
            r_acc <= sum;
            if (r_step == 3'd1) r_a0 <= sat_rot(rnd_v);
            if (r_step == 3'd3) r_a1 <= sat_rot(rnd_v);
        end
    end

    assign o_done = r_done;
    assign o_rot  = r_rot;
    assign o_pos  = r_pos;

endmodule

FILE: rtl/core/serial_arm_forward_kinematics.sv
// Usage: joint angles enter on the input channel (i_valid / o_ready), one word per
// joint, starting at the base joint. use_mass_centre picks the link offset table
// for that joint. The word that carries last_joint closes the chain; the pose
// (rotation Q2.16, position Q5.16 meters) then leaves on the output channel
// (o_valid / i_ready) and the running pose returns to the base pose.
// Each joint word holds o_ready low until the block is idle again: 20 CORDIC
// iterations, a hand-off to the pose update (one 18x18 multiplier runs 21
// multiply-adds, each split into a product and an accumulate phase) and a
// return to idle, so a word is taken only once the last one is through. The
// last joint also loads the output register before o_valid rises. A joint word
// past the seventh leaves the pose unchanged and goes straight back to idle, or
// to loading the output register when it carries last_joint.
// o_ready is high only while the block is idle. The result sits in an output
// register, so the next chain may start while the receiver stalls; the block
// only waits when a new result is ready and the old one is still not taken.
// Reset (i_rst_n low, synchronous) restores the base pose and empties the
// output register.
// Depends on sfk_pkg, sfk_cordic, sfk_pose and the macros header.
`include "serial_arm_forward_kinematics_macros.svh"
module serial_arm_forward_kinematics
    import sfk_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_joint_angle,
    input  logic               i_last_joint,
    input  logic               i_use_mass_centre,
    output logic               o_valid,
    input  logic               i_ready,
    output t_rot               o_rot_00,
    output t_rot               o_rot_01,
    output t_rot               o_rot_02,
    output t_rot               o_rot_10,
    output t_rot               o_rot_11,
    output t_rot               o_rot_12,
    output t_rot               o_rot_20,
    output t_rot               o_rot_21,
    output t_rot               o_rot_22,
    output t_pos               o_pos_x,
    output t_pos               o_pos_y,
    output t_pos               o_pos_z
);

    t_state r_state, n_state;
    logic [2:0] r_cnt, n_cnt;
    logic r_last, r_mass;
    logic r_out_valid;
    t_rot r_out_rot [9];
    t_pos r_out_pos [3];

    logic accept, slot_free, load_out;
    logic cor_start, cor_done, pose_done;
    t_rot cor_cos, cor_sin;
    t_pose_cmd pose_cmd;
    t_rot pose_rot [9];
    t_pos pose_pos [3];

    assign accept    = i_valid && o_ready;
    assign slot_free = !r_out_valid || i_ready;

    sfk_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_angle (i_joint_angle),
        .o_done  (cor_done),
        .o_cos   (cor_cos),
        .o_sin   (cor_sin)
    );

    sfk_pose u_pose (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (pose_cmd),
        .i_cos   (cor_cos),
        .i_sin   (cor_sin),
        .i_joint (r_cnt),
        .i_mass  (r_mass),
        .o_done  (pose_done),
        .o_rot   (pose_rot),
        .o_pos   (pose_pos)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt;
        o_ready        = 1'b0;
        cor_start      = 1'b0;
        pose_cmd.start = 1'b0;
        pose_cmd.clear = 1'b0;
        load_out       = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (r_cnt < 3'(NUM_JOINTS)) begin
                        cor_start = 1'b1;
                        n_state   = S_TRIG;
                    end else if (i_last_joint) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_TRIG: begin
                if (cor_done) begin
                    pose_cmd.start = 1'b1;
                    n_state        = S_MAC;
                end
            end
            S_MAC: begin
                if (pose_done) begin
                    n_cnt   = r_cnt + 3'd1;
                    n_state = r_last ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT: begin
                if (slot_free) begin
                    load_out       = 1'b1;
                    pose_cmd.clear = 1'b1;
                    n_cnt          = '0;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_last <= i_last_joint;
            r_mass <= i_use_mass_centre;
        end
    end

    // hold the result word until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_rot <= pose_rot;
            r_out_pos <= pose_pos;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_rot_00 = r_out_rot[0];
    assign o_rot_01 = r_out_rot[1];
    assign o_rot_02 = r_out_rot[2];
    assign o_rot_10 = r_out_rot[3];
    assign o_rot_11 = r_out_rot[4];
    assign o_rot_12 = r_out_rot[5];
    assign o_rot_20 = r_out_rot[6];
    assign o_rot_21 = r_out_rot[7];
    assign o_rot_22 = r_out_rot[8];
    assign o_pos_x  = r_out_pos[0];
    assign o_pos_y  = r_out_pos[1];
    assign o_pos_z  = r_out_pos[2];

    `SFK_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= 3'(NUM_JOINTS))
    `SFK_ASSERT_IMP(a_cor_in_trig, i_clk, i_rst_n, cor_done, r_state == S_TRIG)
    `SFK_ASSERT_IMP(a_pose_in_mac, i_clk, i_rst_n, pose_done, r_state == S_MAC)
    `SFK_ASSERT_NXT(a_emit_loads, i_clk, i_rst_n, r_state == S_EMIT && slot_free,
                    r_cnt == 3'd0 && o_valid && r_state == S_IDLE)

endmodule

FILE: test/serial_arm_forward_kinematics_test.sv
// Self-checking testbench for serial_arm_forward_kinematics: joint words go in, poses are
// predicted in the bench and compared field by field. Depends on sfk_pkg and the RTL.
module serial_arm_forward_kinematics_test;
    import sfk_pkg::*;

    typedef struct {
        longint rot[9];
        longint pos[3];
    } pose_t;

    localparam longint ARC_TAB [20] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
        83443, 41722, 20861, 10430, 5215, 2608, 1304
    };
    // link offsets in units of 0.1 mm
    localparam int LINK_FRAME [7][3] = '{
        '{0, 0, 2025}, '{0, 2045, 0}, '{0, 0, 2155}, '{0, 1845, 0},
        '{0, 0, 2155}, '{0, 810, 0}, '{0, 0, 450}
    };
    localparam int LINK_MASS [7][3] = '{
        '{0, -300, 1200}, '{3, 590, 420}, '{0, 300, 1300}, '{0, 670, 340},
        '{1, 210, 760}, '{0, 6, 4}, '{0, 0, 200}
    };

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_valid = 0;
    logic o_ready;
    logic signed [15:0] i_joint_angle = 0;
    logic i_last_joint = 0;
    logic i_use_mass_centre = 0;
    logic o_valid;
    logic i_ready = 0;
    t_rot o_rot_00, o_rot_01, o_rot_02, o_rot_10, o_rot_11, o_rot_12;
    t_rot o_rot_20, o_rot_21, o_rot_22;
    t_pos o_pos_x, o_pos_y, o_pos_z;

    serial_arm_forward_kinematics u_dut (.*);

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    longint arm_rot[3][3];
    longint arm_pos[3];
    int joint_idx;
    pose_t pending_poses[$];
    int errors = 0;
    int words_sent = 0;
    int poses_seen = 0;
    int chains_sent = 0;
    bit sending_done = 0;

    function automatic longint clamp(input longint v, input int w);
        longint hi;
        hi = (longint'(1) << (w - 1)) - 1;
        return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
    endfunction

    function automatic longint round_frac(input longint v);
        return (v + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    function automatic longint offset_q(input int tenth_mm);
        longint n;
        longint mag;
        n = longint'(tenth_mm) * (longint'(1) << FRAC_BITS);
        mag = n < 0 ? -n : n;
        mag = (mag + 5000) / 10000;
        return n < 0 ? -mag : mag;
    endfunction

    task automatic sine_cosine(input int a, output longint c, output longint s);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        bit flip;
        x = 652032874;
        y = 0;
        flip = 0;
        if (a > 16384) begin
            a -= 32768;
            flip = 1;
        end else if (a < -16384) begin
            a += 32768;
            flip = 1;
        end
        z = longint'(a) * 65536;
        for (int i = 0; i < 20; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ARC_TAB[i];
            end else begin
                x += dx; y -= dy; z += ARC_TAB[i];
            end
        end
        x = (x + (longint'(1) << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
        y = (y + (longint'(1) << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    task automatic home_pose();
        for (int r = 0; r < 3; r++)
            for (int j = 0; j < 3; j++)
                arm_rot[r][j] = (r == j) ? (longint'(1) << FRAC_BITS) : 0;
        arm_pos[0] = 0;
        arm_pos[1] = 0;
        arm_pos[2] = offset_q(1575);
        joint_idx = 0;
    endtask

    task automatic advance_pose(input int angle, input bit last, input bit cm);
        longint c, s, d, r0, r1;
        longint a[3][3];
        longint t[3];
        pose_t p;
        if (joint_idx < NUM_JOINTS) begin
            sine_cosine(angle, c, s);
            for (int j = 0; j < 3; j++)
                t[j] = offset_q(cm ? LINK_MASS[joint_idx][j] : LINK_FRAME[joint_idx][j]);
            for (int r = 0; r < 3; r++) begin
                r0 = arm_rot[r][0];
                r1 = arm_rot[r][1];
                a[r][0] = clamp(round_frac(r0 * c + r1 * s), ROT_W);
                a[r][1] = clamp(round_frac(r1 * c - r0 * s), ROT_W);
                a[r][2] = arm_rot[r][2];
            end
            for (int r = 0; r < 3; r++) begin
                d = round_frac(a[r][0] * t[0] + a[r][1] * t[1] + a[r][2] * t[2]);
                arm_pos[r] = clamp(arm_pos[r] + d, POS_W);
            end
            for (int r = 0; r < 3; r++) begin
                case (TWIST_TAB[joint_idx])
                    TW_XY: begin
                        arm_rot[r][0] = clamp(-a[r][0], ROT_W);
                        arm_rot[r][1] = a[r][2];
                        arm_rot[r][2] = a[r][1];
                    end
                    TW_X: begin
                        arm_rot[r][0] = a[r][0];
                        arm_rot[r][1] = a[r][2];
                        arm_rot[r][2] = clamp(-a[r][1], ROT_W);
                    end
                    default: begin
                        for (int j = 0; j < 3; j++)
                            arm_rot[r][j] = a[r][j];
                    end
                endcase
            end
            joint_idx++;
        end
        if (last) begin
            for (int k = 0; k < 9; k++)
                p.rot[k] = arm_rot[k / 3][k % 3];
            for (int k = 0; k < 3; k++)
                p.pos[k] = arm_pos[k];
            pending_poses.push_back(p);
            home_pose();
        end
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // predict on every accepted joint word
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            advance_pose(int'(i_joint_angle), i_last_joint, i_use_mass_centre);
            words_sent++;
        end
    end

    always @(posedge i_clk) begin
        pose_t e;
        if (i_rst_n && o_valid && i_ready) begin
            poses_seen++;
            if (pending_poses.size() == 0) begin
                $error("pose word with nothing expected");
                errors++;
            end else begin
                e = pending_poses.pop_front();
                check_field("rot_00", e.rot[0], longint'(o_rot_00));
                check_field("rot_01", e.rot[1], longint'(o_rot_01));
                check_field("rot_02", e.rot[2], longint'(o_rot_02));
                check_field("rot_10", e.rot[3], longint'(o_rot_10));
                check_field("rot_11", e.rot[4], longint'(o_rot_11));
                check_field("rot_12", e.rot[5], longint'(o_rot_12));
                check_field("rot_20", e.rot[6], longint'(o_rot_20));
                check_field("rot_21", e.rot[7], longint'(o_rot_21));
                check_field("rot_22", e.rot[8], longint'(o_rot_22));
                check_field("pos_x", e.pos[0], longint'(o_pos_x));
                check_field("pos_y", e.pos[1], longint'(o_pos_y));
                check_field("pos_z", e.pos[2], longint'(o_pos_z));
            end
        end
    end

    bit burst_mode = 0;

    task automatic send_word(input logic signed [15:0] angle, input bit last, input bit cm);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1;
        i_joint_angle <= angle;
        i_last_joint <= last;
        i_use_mass_centre <= cm;
        do @(posedge i_clk); while (!o_ready);
    endtask

    function automatic logic signed [15:0] pick_angle();
        logic signed [15:0] edge_angles [8] = '{
            -16'sd32768, 16'sd32767, 16'sd16384, -16'sd16384,
            16'sd16385, -16'sd16385, 16'sd0, -16'sd1
        };
        if ($urandom_range(0, 7) == 0)
            return edge_angles[$urandom_range(0, 7)];
        return 16'($urandom);
    endfunction

    // receiver: random stalls, plus one long hold-off to back the block up
    initial begin
        int stall;
        bit held;
        held = 0;
        @(posedge i_rst_n);
        forever begin
            if (!held && poses_seen == 4) begin
                stall = 600;
                held = 1;
            end else begin
                stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
            end
            if (stall > 0) begin
                i_ready <= 0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    typedef struct {
        logic signed [15:0] angle;
        bit last;
        bit cm;
    } joint_row_t;

    // directed words: angle extremes, quadrant edges, too many joints, one-joint chain
    joint_row_t directed [] = '{
        '{16'sd0, 1, 0},
        '{-16'sd32768, 0, 0}, '{16'sd32767, 0, 1}, '{16'sd16384, 0, 0},
        '{-16'sd16384, 0, 1}, '{16'sd16385, 0, 0}, '{-16'sd16385, 0, 1},
        '{16'sd8192, 1, 0},
        '{16'sd0, 0, 1}, '{16'sd0, 0, 1}, '{16'sd0, 0, 1}, '{16'sd0, 0, 1},
        '{16'sd0, 0, 1}, '{16'sd0, 0, 1}, '{16'sd0, 0, 1}, '{16'sd1234, 0, 0},
        '{-16'sd32768, 1, 1},
        '{16'sd32767, 0, 0}, '{16'sd32767, 0, 0}, '{16'sd32767, 0, 0},
        '{16'sd32767, 0, 0}, '{16'sd32767, 0, 0}, '{16'sd32767, 0, 0},
        '{16'sd32767, 1, 0}
    };

    initial begin
        int len;
        home_pose();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        foreach (directed[k])
            send_word(directed[k].angle, directed[k].last, directed[k].cm);
        chains_sent = 4;
        while (words_sent < 1750) begin
            burst_mode = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 99) < 85) begin
                len = $urandom_range(1, 9);
                for (int k = 0; k < len; k++)
                    send_word(pick_angle(), k == len - 1, $urandom_range(0, 1));
                chains_sent++;
            end else begin
                send_word(pick_angle(), $urandom_range(0, 1), $urandom_range(0, 1));
            end
        end
        i_valid <= 0;
        sending_done = 1;
    end

    initial begin
        wait (sending_done);
        while (pending_poses.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("Sent %0d joint words in about %0d chains, checked %0d poses.",
                 words_sent, chains_sent, poses_seen);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #4000000;
        $display("Timeout waiting for the block.");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
